>>> rtl/tdmh_pkg.sv
// Package for the timer deadline min-heap: sizes, command and status codes, FSM states.
// Used by timer_deadline_min_heap.sv.
package tdmh_pkg;
    localparam int unsigned CAPACITY   = 1024;
    localparam int unsigned MAX_EXPIRE = 16;
    localparam int unsigned AW  = $clog2(CAPACITY);
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned EW  = $clog2(MAX_EXPIRE + 1);
    localparam int unsigned DW  = 96;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_EXPIRE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_BADPOS  = 3'd3;
    localparam logic [2:0] ST_EXPIRED = 3'd4;
    localparam logic [2:0] ST_NONE    = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_A, S_RD_B, S_DEC, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_WAIT, S_DN_CMP, S_PLACE, S_TOP_RD, S_TOP_WAIT, S_EMIT
    } t_state;
endpackage

>>> rtl/tdmh_ram.sv
// Generic single-write, two-read synchronous RAM with registered read data.
// No dependencies.
module tdmh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

>>> rtl/timer_deadline_min_heap.sv
// Top level of the timer deadline min-heap: command FSM around one heap RAM.
// Depends on tdmh_pkg and tdmh_ram.
//
// Channel  Dir  Contents
// s_axis   in   tdata: command, interval_ms, base_time, user_tag, heap_position, now_ms, end_ms
// m_axis   out  tdata: status, deadline_out, tag_out, timer_count, next_wait; tlast: last_result
//
// One command at a time. An add sifts the new entry up; a remove or pop moves the last
// entry into the gap and sifts it up or down as needed; a rejected command only reads
// the top. Each further expired timer repeats the pop sequence from its RAM reads. Reset
// is synchronous and clears only the count, the FSM and the output valid flag. A result
// waits in the output register; the FSM stalls at its next result until the master
// side takes the one before.
module timer_deadline_min_heap (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] command, [33:2] interval_ms, [97:34] base_time, [129:98] user_tag,
    // [140:130] heap_position, [204:141] now_ms, [268:205] end_ms
    input  logic [271:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [66:3] deadline_out, [98:67] tag_out, [109:99] timer_count,
    // [141:110] next_wait
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    tdmh_pkg::t_state r_state, n_state;

    logic [1:0]  r_cmd, n_cmd;
    logic [63:0] r_now, n_now, r_end, n_end;
    logic [tdmh_pkg::CW-1:0] r_count, n_count;
    logic [tdmh_pkg::AW-1:0] r_idx, n_idx;
    logic [63:0] r_d, n_d;
    logic [31:0] r_t, n_t;
    logic [63:0] r_od, n_od;
    logic [31:0] r_ot, n_ot;
    logic [2:0]  r_st, n_st;
    logic [tdmh_pkg::EW-1:0] r_k, n_k;
    logic [63:0] r_top, n_top;
    logic        r_ovalid, n_ovalid;
    logic [143:0] r_odata, n_odata;
    logic        r_olast, n_olast;
    logic        r_dnboth, n_dnboth;

    logic        we;
    logic [tdmh_pkg::AW-1:0] waddr, ra, rb;
    logic [tdmh_pkg::DW-1:0] wdata, qa, qb;

    tdmh_ram #(.WIDTH(tdmh_pkg::DW), .DEPTH(tdmh_pkg::CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra), .o_rdata_a(qa), .i_raddr_b(rb), .o_rdata_b(qb)
    );

    logic [64:0] sum;
    logic [63:0] diff;
    logic [31:0] wait_v;
    logic [tdmh_pkg::CW:0] left_w;
    logic [tdmh_pkg::CW:0] right_w;
    logic [63:0] pick_d;
    logic        pick_right;

    assign sum   = {1'b0, s_axis_tdata[97:34]} + {33'b0, s_axis_tdata[33:2]};
    assign diff  = r_top - r_now;
    assign left_w  = {r_idx, 1'b1} + (tdmh_pkg::CW + 1)'(0);
    assign right_w = left_w + (tdmh_pkg::CW + 1)'(1);
    assign pick_right = r_dnboth && !(qa[63:0] < qb[63:0]);
    assign pick_d = pick_right ? qb[63:0] : qa[63:0];

    always_comb begin
        if (r_count == '0) begin
            wait_v = 32'hFFFF_FFFF;
        end else if (r_top <= r_now) begin
            wait_v = '0;
        end else if (diff > 64'h7FFF_FFFF) begin
            wait_v = 32'h7FFF_FFFF;
        end else begin
            wait_v = diff[31:0];
        end
    end

    assign s_axis_tready = (r_state == tdmh_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tdmh_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_cmd <= n_cmd; r_now <= n_now; r_end <= n_end;
        r_idx <= n_idx; r_d <= n_d; r_t <= n_t; r_od <= n_od; r_ot <= n_ot;
        r_st <= n_st; r_k <= n_k; r_top <= n_top;
        r_odata <= n_odata; r_olast <= n_olast; r_dnboth <= n_dnboth;
    end

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_now = r_now; n_end = r_end;
        n_count = r_count; n_idx = r_idx; n_d = r_d; n_t = r_t;
        n_od = r_od; n_ot = r_ot; n_st = r_st; n_k = r_k; n_top = r_top;
        n_ovalid = r_ovalid; n_odata = r_odata; n_olast = r_olast;
        n_dnboth = r_dnboth;
        we = 1'b0; waddr = r_idx; wdata = {r_t, r_d};
        ra = r_idx; rb = r_idx;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            tdmh_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd = s_axis_tdata[1:0];
                    n_now = s_axis_tdata[204:141];
                    n_end = s_axis_tdata[268:205];
                    n_k   = '0;
                    n_od  = '0; n_ot = '0;
                    n_state = tdmh_pkg::S_EMIT;
                    case (s_axis_tdata[1:0])
                        tdmh_pkg::CMD_ADD: begin
                            if (r_count >= tdmh_pkg::CW'(tdmh_pkg::CAPACITY)) begin
                                n_st = tdmh_pkg::ST_FULL;
                                n_state = tdmh_pkg::S_TOP_RD;
                            end else begin
                                n_d = sum[64] ? '1 : sum[63:0];
                                n_t = s_axis_tdata[129:98];
                                n_od = n_d; n_ot = n_t;
                                n_st = tdmh_pkg::ST_OK;
                                n_idx = r_count[tdmh_pkg::AW-1:0];
                                n_count = r_count + 1'b1;
                                n_state = tdmh_pkg::S_UP_RD;
                            end
                        end
                        tdmh_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_st = tdmh_pkg::ST_EMPTY;
                                n_state = tdmh_pkg::S_TOP_RD;
                            end else if (s_axis_tdata[140:130] == '0 ||
                                         s_axis_tdata[140:130] > r_count) begin
                                n_st = tdmh_pkg::ST_BADPOS;
                                n_state = tdmh_pkg::S_TOP_RD;
                            end else begin
                                n_st = tdmh_pkg::ST_OK;
                                n_idx = tdmh_pkg::AW'(s_axis_tdata[140:130] - 1'b1);
                                n_state = tdmh_pkg::S_RD_A;
                            end
                        end
                        tdmh_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                n_st = tdmh_pkg::ST_EMPTY;
                                n_state = tdmh_pkg::S_TOP_RD;
                            end else begin
                                n_st = tdmh_pkg::ST_OK;
                                n_idx = '0;
                                n_state = tdmh_pkg::S_RD_A;
                            end
                        end
                        default: begin
                            n_st = tdmh_pkg::ST_EXPIRED;
                            n_idx = '0;
                            n_state = tdmh_pkg::S_RD_A;
                        end
                    endcase
                end
            end
            // Read the target entry and the last entry together.
            tdmh_pkg::S_RD_A: begin
                ra = r_idx;
                rb = tdmh_pkg::AW'(r_count - 1'b1);
                n_state = tdmh_pkg::S_RD_B;
            end
            tdmh_pkg::S_RD_B: begin
                ra = r_idx;
                rb = tdmh_pkg::AW'(r_count - 1'b1);
                n_state = tdmh_pkg::S_DEC;
            end
            tdmh_pkg::S_DEC: begin
                if (r_cmd == tdmh_pkg::CMD_EXPIRE &&
                    (r_count == '0 || qa[63:0] > r_now || r_now > r_end ||
                     r_k == tdmh_pkg::EW'(tdmh_pkg::MAX_EXPIRE))) begin
                    if (r_k == '0) begin
                        n_st = tdmh_pkg::ST_NONE;
                        n_od = '0; n_ot = '0;
                        n_state = tdmh_pkg::S_TOP_RD;
                    end else begin
                        n_state = tdmh_pkg::S_IDLE;
                    end
                end else begin
                    n_od = qa[63:0]; n_ot = qa[95:64];
                    n_count = r_count - 1'b1;
                    n_d = qb[63:0]; n_t = qb[95:64];
                    if ({1'b0, r_idx} >= r_count - 1'b1) begin
                        n_state = tdmh_pkg::S_TOP_RD;
                    end else if (qb[63:0] < qa[63:0]) begin
                        n_state = tdmh_pkg::S_UP_RD;
                    end else if (qb[63:0] > qa[63:0]) begin
                        n_state = tdmh_pkg::S_DN_RD;
                    end else begin
                        n_state = tdmh_pkg::S_PLACE;
                    end
                end
            end
            tdmh_pkg::S_UP_RD: begin
                if (r_idx == '0) begin
                    n_state = tdmh_pkg::S_PLACE;
                end else begin
                    ra = (r_idx - 1'b1) >> 1;
                    n_state = tdmh_pkg::S_UP_CMP;
                end
            end
            tdmh_pkg::S_UP_CMP: begin
                if (r_d < qa[63:0]) begin
                    we = 1'b1; waddr = r_idx; wdata = qa;
                    n_idx = (r_idx - 1'b1) >> 1;
                    n_state = tdmh_pkg::S_UP_RD;
                end else begin
                    n_state = tdmh_pkg::S_PLACE;
                end
            end
            tdmh_pkg::S_DN_RD: begin
                if (left_w >= {1'b0, r_count}) begin
                    n_state = tdmh_pkg::S_PLACE;
                end else begin
                    ra = left_w[tdmh_pkg::AW-1:0];
                    rb = right_w[tdmh_pkg::AW-1:0];
                    n_dnboth = right_w < {1'b0, r_count};
                    n_state = tdmh_pkg::S_DN_WAIT;
                end
            end
            tdmh_pkg::S_DN_WAIT: begin
                ra = left_w[tdmh_pkg::AW-1:0];
                rb = right_w[tdmh_pkg::AW-1:0];
                n_state = tdmh_pkg::S_DN_CMP;
            end
            tdmh_pkg::S_DN_CMP: begin
                if (r_d <= pick_d) begin
                    n_state = tdmh_pkg::S_PLACE;
                end else begin
                    we = 1'b1; waddr = r_idx;
                    wdata = pick_right ? qb : qa;
                    n_idx = pick_right ? right_w[tdmh_pkg::AW-1:0]
                                       : left_w[tdmh_pkg::AW-1:0];
                    n_state = tdmh_pkg::S_DN_RD;
                end
            end
            tdmh_pkg::S_PLACE: begin
                we = 1'b1; waddr = r_idx; wdata = {r_t, r_d};
                n_state = tdmh_pkg::S_TOP_RD;
            end
            tdmh_pkg::S_TOP_RD: begin
                ra = '0;
                n_state = tdmh_pkg::S_TOP_WAIT;
            end
            tdmh_pkg::S_TOP_WAIT: begin
                n_top = qa[63:0];
                n_state = tdmh_pkg::S_EMIT;
            end
            // An expired result is last unless a timer is due, now <= end and MAX_EXPIRE not hit.
            tdmh_pkg::S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata = {2'b0, wait_v, r_count, r_ot, r_od, r_st};
                    n_k = r_k + 1'b1;
                    if (r_cmd == tdmh_pkg::CMD_EXPIRE && r_st == tdmh_pkg::ST_EXPIRED &&
                        r_count != '0 && r_top <= r_now && r_now <= r_end &&
                        r_k != tdmh_pkg::EW'(tdmh_pkg::MAX_EXPIRE - 1)) begin
                        n_olast = 1'b0;
                        n_idx = '0;
                        n_state = tdmh_pkg::S_RD_A;
                    end else begin
                        n_olast = 1'b1;
                        n_state = tdmh_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = tdmh_pkg::S_IDLE;
        endcase
    end
endmodule
